/* design/wlvl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wlvl_pkg;

  localparam int VALUE_W        = 31;
  localparam int WORD_W         = VALUE_W + 1;
  localparam int SLOT_OUT_W     = 8;
  localparam int DEF_SLOT_COUNT = 256;

  localparam logic MODE_STORE   = 1'b0;
  localparam logic MODE_RECOVER = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]    latest_value;
    logic [SLOT_OUT_W-1:0] write_slot_out;
    logic                  phase_out;
    logic                  wrote;
  } out_item_t;

  // top -> sequencer
  typedef struct packed {
    logic     start;
    in_item_t item;
  } ctl_cmd_t;

  // sequencer -> top
  typedef struct packed {
    logic      idle;
    logic      done;
    out_item_t result;
  } ctl_stat_t;

endpackage

`default_nettype wire

/* design/wlvl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wlvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* design/wlvl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module wlvl_ctrl #(
  parameter int SLOT_COUNT = wlvl_pkg::DEF_SLOT_COUNT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wlvl_pkg::ctl_cmd_t  cmd,
  output wlvl_pkg::ctl_stat_t      stat
);

  import wlvl_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W:0] SLOT_END = (SLOT_W+1)'(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEAD,
    S_SCAN
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    write_slot_r, write_slot_nxt;
  logic                 phase_r, phase_nxt;
  logic [VALUE_W-1:0]   last_value_r, last_value_nxt;
  logic [SLOT_W:0]      fill_r, fill_nxt;
  logic [SLOT_W-1:0]    scan_slot_r, scan_slot_nxt;
  logic                 lead_r, lead_nxt;
  logic [VALUE_W-1:0]   found_r, found_nxt;
  logic                 rd_ok_r, rd_ok_nxt;

  logic [SLOT_W-1:0]    inc_base;
  logic [SLOT_W:0]      slot_inc;
  logic                 wrap;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;
  logic [SLOT_W-1:0]    rd_addr;
  logic [WORD_W-1:0]    rd_data;
  logic [WORD_W-1:0]    word_m;
  logic                 done;
  logic                 wrote;

  // Shared slot incrementer: store advance and scan walk both use it
  assign slot_inc = {1'b0, inc_base} + (SLOT_W+1)'(1);
  assign wrap     = (slot_inc == SLOT_END);

  // Slots at or beyond the fill count were never written: they read as erased
  assign word_m = rd_ok_r ? rd_data : '1;

  always_comb begin
    state_nxt      = state_r;
    write_slot_nxt = write_slot_r;
    phase_nxt      = phase_r;
    last_value_nxt = last_value_r;
    fill_nxt       = fill_r;
    scan_slot_nxt  = scan_slot_r;
    lead_nxt       = lead_r;
    found_nxt      = found_r;
    inc_base       = write_slot_r;
    wr_en          = 1'b0;
    wr_data        = {phase_r, cmd.item.new_value};
    done           = 1'b0;
    wrote          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          if (cmd.item.mode == MODE_RECOVER) begin
            state_nxt = S_LEAD;
          end else begin
            done = 1'b1;
            if (cmd.item.new_value != last_value_r) begin
              wr_en          = 1'b1;
              wrote          = 1'b1;
              last_value_nxt = cmd.item.new_value;
              if (wrap) begin
                write_slot_nxt = '0;
                phase_nxt      = ~phase_r;
              end else begin
                write_slot_nxt = slot_inc[SLOT_W-1:0];
              end
              if ({1'b0, write_slot_r} == fill_r) begin
                fill_nxt = fill_r + (SLOT_W+1)'(1);
              end
            end
          end
        end
      end
      S_LEAD: begin
        inc_base      = '0;
        lead_nxt      = word_m[WORD_W-1];
        found_nxt     = word_m[VALUE_W-1:0];
        scan_slot_nxt = slot_inc[SLOT_W-1:0];
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        inc_base = scan_slot_r;
        if (word_m[WORD_W-1] != lead_r) begin
          done           = 1'b1;
          write_slot_nxt = scan_slot_r;
          phase_nxt      = lead_r;
          last_value_nxt = found_r;
          state_nxt      = S_IDLE;
        end else if (wrap) begin
          // whole ring carries one phase: last slot is newest
          done           = 1'b1;
          write_slot_nxt = '0;
          phase_nxt      = ~lead_r;
          last_value_nxt = word_m[VALUE_W-1:0];
          state_nxt      = S_IDLE;
        end else begin
          found_nxt     = word_m[VALUE_W-1:0];
          scan_slot_nxt = slot_inc[SLOT_W-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_IDLE || wrap) begin
      rd_addr = '0;
    end else begin
      rd_addr = slot_inc[SLOT_W-1:0];
    end
    rd_ok_nxt = ({1'b0, rd_addr} < fill_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      write_slot_r <= '0;
      phase_r      <= 1'b0;
      last_value_r <= '0;
      fill_r       <= '0;
      rd_ok_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      phase_r      <= phase_nxt;
      last_value_r <= last_value_nxt;
      fill_r       <= fill_nxt;
      rd_ok_r      <= rd_ok_nxt;
    end
    scan_slot_r <= scan_slot_nxt;
    lead_r      <= lead_nxt;
    found_r     <= found_nxt;
  end

  wlvl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_slot_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.idle                  = (state_r == S_IDLE);
    stat.done                  = done;
    stat.result.latest_value   = last_value_nxt;
    stat.result.write_slot_out = SLOT_OUT_W'(write_slot_nxt);
    stat.result.phase_out      = phase_nxt;
    stat.result.wrote          = wrote;
  end

endmodule

`default_nettype wire

/* design/wear_leveled_value_log.sv */
`timescale 1ns / 1ps
`default_nettype none

// Wear-levelled ring log of 31-bit values, one word per slot with a phase bit on top.
// A store transaction is taken and its result registered at the next edge, so stores
// run at one per cycle while the output is accepted: the single write port of the
// slot RAM does the work. A store of the value last stored writes nothing. A recover
// transaction walks the ring from slot 0 through the shared slot incrementer and the
// RAM read port, one slot a cycle, until the phase changes or the last slot is read,
// and the input is held off meanwhile. Erased state needs no clearing pass after
// reset: a fill count marks the slots ever written, and the rest read as all ones.
module wear_leveled_value_log #(
  parameter int SLOT_COUNT = wlvl_pkg::DEF_SLOT_COUNT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wlvl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wlvl_pkg::out_item_t      out_data
);

  import wlvl_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // output slot frees this cycle if its transaction is being taken
  assign in_ready  = stat.idle && (!out_valid_r || out_ready);
  assign cmd       = {in_valid && in_ready, in_data};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = stat.result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wlvl_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // a finished result must never overwrite one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending output");

  // a store transaction yields its result at the next edge
  a_store_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && in_data.mode == MODE_STORE) |=> out_valid)
    else $error("store result missing");

  // a recover transaction holds off the input while it scans
  a_recover_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && in_data.mode == MODE_RECOVER) |=> (!in_ready && !out_valid))
    else $error("input taken during recover scan");

endmodule

`default_nettype wire
